// ----- sv/rcppm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcppm_pkg: shared types and constants of the PPM frame decoder
// Transfer payloads, register indexes, read kinds, reset values and scaling constants.
// ----------------------------------------------------------------------------
package rcppm_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_OFFSET = 3'd5;

  localparam logic [15:0] GLITCH_MIN_RST  = 16'd10;
  localparam logic [15:0] START_MIN_RST   = 16'd6175;
  localparam logic [15:0] START_MAX_RST   = 16'd15225;
  localparam logic [15:0] PULSE_MIN_RST   = 16'd950;
  localparam logic [15:0] PULSE_MAX_RST   = 16'd2100;
  localparam logic [7:0]  CHAN_OFFSET_RST = 8'd25;

  localparam logic        OP_EDGE = 1'b0;
  localparam logic        OP_READ = 1'b1;

  localparam logic [1:0]  KIND_JOYSTICK = 2'd0;
  localparam logic [1:0]  KIND_SWITCH2  = 2'd1;
  localparam logic [1:0]  KIND_SWITCH3  = 2'd2;

  localparam logic [9:0]  VALUE_MAX   = 10'd1000;
  localparam logic [9:0]  VALUE_MID   = 10'd500;
  localparam logic [9:0]  SW3_HIGH    = 10'd667;
  localparam logic [9:0]  SW3_LOW     = 10'd334;
  localparam logic [33:0] BASE_US     = 34'd1000;
  // floor(m / 5) == (m * 205) >> 10 for m below 1024
  localparam logic [7:0]  RECIP5      = 8'd205;

  typedef struct packed {
    logic        operation;
    logic [31:0] edge_time_us;
    logic [3:0]  read_channel;
    logic [1:0]  read_kind;
  } in_item_t;

  typedef struct packed {
    logic              in_sync;
    logic              sync_lost;
    logic              value_written;
    logic [3:0]        written_channel;
    logic [9:0]        written_value;
    logic signed [7:0] read_value;
  } out_item_t;

endpackage

// ----- sv/rc_ppm_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rc_ppm_frame_decoder: PPM pulse train decoder with channel read-back
// Decodes rising-edge timestamps into channel values and converts stored
// values into joystick or switch positions on request.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while out_stall does not hold the result
// register. The item is registered in the input register, then passes
// through the interval, window and clamp logic into the result register.
// Every item gives exactly one result, in order. The sustained rate of one
// item per cycle is set by the update of the last-edge time, sync flag and
// channel index, which each item reads and writes in its compute cycle.
// Configuration writes are always taken (cfg_ready is high) and must only be
// made while the block is idle.
module rc_ppm_frame_decoder #(
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcppm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcppm_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcppm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcppm_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int unsigned CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0]      CH_COUNT = 5'(CHANNEL_COUNT);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNEL_COUNT - 1);

  logic [15:0] glitch_min_r, start_min_r, start_max_r, pulse_min_r, pulse_max_r;
  logic [7:0]  chan_offset_r;

  logic                 s1_valid_r;
  rcppm_pkg::in_item_t  s1_item_r;
  logic                 out_valid_r;
  rcppm_pkg::out_item_t out_item_r;

  logic [31:0]     last_edge_r, last_edge_nxt;
  logic            sync_r, sync_nxt;
  logic [CH_W-1:0] next_ch_r, next_ch_nxt;
  logic [9:0]      chan_val_r [CHANNEL_COUNT];

  logic out_adv, s1_move;
  rcppm_pkg::out_item_t res;

  logic [31:0] delta;
  logic [33:0] diff;
  logic [9:0]  clamped;
  logic        is_glitch, is_start, is_pulse, do_write;

  logic [9:0]  rd_val;
  logic        rd_in_range;
  logic [10:0] centred;
  logic        neg;
  logic [10:0] mag;
  logic [16:0] prod;
  logic [7:0]  quot;
  logic [7:0]  joy;

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  // edge path
  always_comb begin
    delta     = s1_item_r.edge_time_us - last_edge_r;
    is_glitch = delta < {16'd0, glitch_min_r};
    is_start  = (delta >= {16'd0, start_min_r}) && (delta <= {16'd0, start_max_r});
    is_pulse  = (delta >= {16'd0, pulse_min_r}) && (delta <= {16'd0, pulse_max_r});
    diff      = {2'b00, delta} - {26'd0, chan_offset_r} - rcppm_pkg::BASE_US;
    if (diff[33]) begin
      clamped = 10'd0;
    end else if (diff > {24'd0, rcppm_pkg::VALUE_MAX}) begin
      clamped = rcppm_pkg::VALUE_MAX;
    end else begin
      clamped = diff[9:0];
    end
  end

  // read path
  always_comb begin
    rd_in_range = {1'b0, s1_item_r.read_channel} < CH_COUNT;
    rd_val      = chan_val_r[s1_item_r.read_channel[CH_W-1:0]];
    centred     = {1'b0, rd_val} - {1'b0, rcppm_pkg::VALUE_MID};
    neg         = centred[10];
    mag         = neg ? (11'd0 - centred) : centred;
    prod        = 17'(mag[8:0]) * 17'(rcppm_pkg::RECIP5);
    quot        = {1'b0, prod[16:10]};
    joy         = neg ? (8'd0 - quot) : quot;
  end

  always_comb begin
    last_edge_nxt = last_edge_r;
    sync_nxt      = sync_r;
    next_ch_nxt   = next_ch_r;
    do_write      = 1'b0;
    res           = '0;
    if (s1_item_r.operation == rcppm_pkg::OP_EDGE) begin
      if (!is_glitch) begin
        last_edge_nxt = s1_item_r.edge_time_us;
        if (is_start) begin
          sync_nxt    = 1'b1;
          next_ch_nxt = '0;
        end else if (is_pulse) begin
          if (sync_r) begin
            do_write              = 1'b1;
            res.value_written     = 1'b1;
            res.written_channel   = 4'(next_ch_r);
            res.written_value     = clamped;
            next_ch_nxt           = (next_ch_r == CH_LAST) ? '0 : next_ch_r + 1'b1;
          end
        end else begin
          sync_nxt      = 1'b0;
          res.sync_lost = 1'b1;
        end
      end
    end else if (rd_in_range) begin
      case (s1_item_r.read_kind)
        rcppm_pkg::KIND_JOYSTICK: res.read_value = joy;
        rcppm_pkg::KIND_SWITCH2:
          res.read_value = (rd_val > rcppm_pkg::VALUE_MID) ? 8'sd1 : 8'sd0;
        rcppm_pkg::KIND_SWITCH3: begin
          if (rd_val >= rcppm_pkg::SW3_HIGH) begin
            res.read_value = 8'sd2;
          end else if (rd_val >= rcppm_pkg::SW3_LOW) begin
            res.read_value = 8'sd1;
          end else begin
            res.read_value = 8'sd0;
          end
        end
        default: res.read_value = 8'sd0;
      endcase
    end
    res.in_sync = sync_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glitch_min_r  <= rcppm_pkg::GLITCH_MIN_RST;
      start_min_r   <= rcppm_pkg::START_MIN_RST;
      start_max_r   <= rcppm_pkg::START_MAX_RST;
      pulse_min_r   <= rcppm_pkg::PULSE_MIN_RST;
      pulse_max_r   <= rcppm_pkg::PULSE_MAX_RST;
      chan_offset_r <= rcppm_pkg::CHAN_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcppm_pkg::REG_GLITCH_MIN:  glitch_min_r  <= cfg_data;
        rcppm_pkg::REG_START_MIN:   start_min_r   <= cfg_data;
        rcppm_pkg::REG_START_MAX:   start_max_r   <= cfg_data;
        rcppm_pkg::REG_PULSE_MIN:   pulse_min_r   <= cfg_data;
        rcppm_pkg::REG_PULSE_MAX:   pulse_max_r   <= cfg_data;
        rcppm_pkg::REG_CHAN_OFFSET: chan_offset_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_edge_r <= '0;
      sync_r      <= 1'b0;
      next_ch_r   <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_val_r[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        last_edge_r <= last_edge_nxt;
        sync_r      <= sync_nxt;
        next_ch_r   <= next_ch_nxt;
        if (do_write) begin
          chan_val_r[next_ch_r] <= clamped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (s1_move) begin
      out_item_r <= res;
    end
  end

endmodule

// ----- sv/rcppm_checker.sv -----
// ----------------------------------------------------------------------------
// rcppm_checker: port-level checks for the PPM frame decoder
// Watches the result channel for reset, stall hold and consistency of the decoded flags and values.
// ----------------------------------------------------------------------------
module rcppm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input rcppm_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transfer changed");

  a_lost_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sync_lost |-> !out_data.in_sync && !out_data.value_written)
    else $error("sync loss reported while in sync");

  a_write_synced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_written |->
      out_data.in_sync && (out_data.written_value <= rcppm_pkg::VALUE_MAX)
      && (out_data.read_value == 8'sd0))
    else $error("channel store without sync or out of range");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_value != 8'sd0) |->
      (out_data.read_value >= -8'sd100) && (out_data.read_value <= 8'sd100)
      && !out_data.sync_lost && (out_data.written_value == 10'd0))
    else $error("read result out of range or mixed with edge flags");

endmodule

bind rc_ppm_frame_decoder rcppm_checker u_rcppm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
